[design/sqtri_pkg.sv]
// ----------------------------------------------------------------------------
// sqtri_pkg: shared types and constants for the square/triangle tone mixer
// Widths, fixed-point constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package sqtri_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int PERIOD_WIDTH = 16;
  localparam int GAIN_WIDTH   = 16;
  localparam int GAIN_FRAC    = 15;

  localparam int QUO_W   = SAMPLE_WIDTH + 1;
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int WAVE_W  = SAMPLE_WIDTH + 3;
  localparam int PROD_W  = WAVE_W + GAIN_WIDTH + 1;
  localparam int CFG_W   = 2;
  localparam int CFG_DATA_W = (PERIOD_WIDTH > GAIN_WIDTH) ? PERIOD_WIDTH : GAIN_WIDTH;

  localparam logic [CFG_W-1:0] REG_PERIOD = CFG_W'(0);
  localparam logic [CFG_W-1:0] REG_MODE   = CFG_W'(1);
  localparam logic [CFG_W-1:0] REG_GAIN   = CFG_W'(2);

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(100);
  localparam logic [GAIN_WIDTH-1:0]   GAIN_RESET   = GAIN_WIDTH'(3277);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  localparam logic signed [WAVE_W-1:0] WAVE_ONE   = WAVE_W'(1) <<< (SAMPLE_WIDTH - 1);
  localparam logic signed [WAVE_W-1:0] WAVE_THREE = WAVE_W'(3) <<< (SAMPLE_WIDTH - 1);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [PROD_W-1:0] SMP_MAX    = (PROD_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SMP_MIN    = -(PROD_W'(1) <<< (SAMPLE_WIDTH - 1));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

[design/square_triangle_tone_mixer_unit.sv]
// ----------------------------------------------------------------------------
// square_triangle_tone_mixer_unit: square/triangle tone added into a mix
// One input word per sample tick; one saturated output word per input word.
// ----------------------------------------------------------------------------
// Each word carries the current mix sample and a restart flag that zeroes the
// phase counter. In triangle mode an accepted word passes through a serial
// restoring divider that forms 4*ONE*phase/period, 17 quotient bits at one
// quotient bit per cycle, then a gain multiply step and then a round, add
// and saturate step into the result register. Square mode bypasses the
// divider and goes straight to the gain multiply.
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register and the next input word may be taken meanwhile. The
// sequencer holds in its last step while the output register is still full.
// Write period_len, wave_mode and gain only while no word is in flight.
// ----------------------------------------------------------------------------
module square_triangle_tone_mixer_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sqtri_pkg::SAMPLE_WIDTH-1:0] mix_in,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sqtri_pkg::SAMPLE_WIDTH-1:0] mix_out,
  input  logic                                  cfg_write,
  input  logic [sqtri_pkg::CFG_W-1:0]           cfg_index,
  input  logic [sqtri_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sqtri_pkg::*;

  state_t state;

  logic [PERIOD_WIDTH-1:0] period_len;
  logic                    wave_mode;
  logic [GAIN_WIDTH-1:0]   gain;
  logic [PERIOD_WIDTH-1:0] phase_count;

  logic signed [SAMPLE_WIDTH-1:0] mix_q;
  logic                           rising;
  logic [PERIOD_WIDTH-1:0]        div_rem;
  logic [QUO_W-1:0]               div_quo;
  logic [CNT_W-1:0]               div_cnt;
  logic signed [PROD_W-1:0]       prod;

  logic [PERIOD_WIDTH-1:0] per_eff;
  logic [PERIOD_WIDTH-1:0] ph_start;
  logic [PERIOD_WIDTH-1:0] ph_use;
  logic [PERIOD_WIDTH:0]   ph_inc;
  logic [PERIOD_WIDTH-1:0] phase_count_next;
  logic                    rising_next;
  logic [PERIOD_WIDTH:0]   rem_sh;
  logic                    rem_ge;
  logic [PERIOD_WIDTH:0]   rem_sub;
  logic signed [WAVE_W-1:0] wave;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] total;
  logic signed [SAMPLE_WIDTH-1:0] sat;
  logic                    in_fire;
  logic                    out_load;

  assign in_ready = (state == S_IDLE) && !rst;
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    per_eff  = (period_len == '0) ? PERIOD_WIDTH'(1) : period_len;
    ph_start = restart ? '0 : phase_count;
    ph_use   = (ph_start >= per_eff) ? '0 : ph_start;
    ph_inc   = {1'b0, ph_use} + (PERIOD_WIDTH + 1)'(1);
    phase_count_next = (ph_inc >= {1'b0, per_eff}) ? '0 : ph_inc[PERIOD_WIDTH-1:0];
    rising_next = {ph_use, 1'b0} < {1'b0, per_eff};
  end

  always_comb begin
    rem_sh  = {div_rem, 1'b0};
    rem_ge  = rem_sh >= {1'b0, per_eff};
    rem_sub = rem_sh - {1'b0, per_eff};
  end

  always_comb begin
    if (wave_mode) begin
      if (rising) begin
        wave = signed'(WAVE_W'(div_quo)) - WAVE_ONE;
      end else begin
        wave = WAVE_THREE - signed'(WAVE_W'(div_quo));
      end
    end else begin
      wave = rising ? WAVE_ONE : -WAVE_ONE;
    end
  end

  always_comb begin
    rounded = (prod + ROUND_HALF) >>> GAIN_FRAC;
    total   = PROD_W'(mix_q) + rounded;
    if (total > SMP_MAX) begin
      sat = SAMPLE_WIDTH'(SMP_MAX);
    end else if (total < SMP_MIN) begin
      sat = SAMPLE_WIDTH'(SMP_MIN);
    end else begin
      sat = total[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_len <= PERIOD_RESET;
      wave_mode  <= 1'b0;
      gain       <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PERIOD: period_len <= cfg_data[PERIOD_WIDTH-1:0];
        REG_MODE:   wave_mode  <= cfg_data[0];
        REG_GAIN:   gain       <= cfg_data[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            phase_count <= phase_count_next;
            state       <= wave_mode ? S_DIV : S_MUL;
          end
        end
        S_DIV: begin
          if (div_cnt == DIV_LAST) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mix_q   <= mix_in;
        rising  <= rising_next;
        div_rem <= ph_use;
        div_quo <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        div_rem <= rem_ge ? rem_sub[PERIOD_WIDTH-1:0] : rem_sh[PERIOD_WIDTH-1:0];
        div_quo <= {div_quo[QUO_W-2:0], rem_ge};
        div_cnt <= div_cnt + CNT_W'(1);
      end
      S_MUL: begin
        prod <= PROD_W'(wave) * PROD_W'(signed'({1'b0, gain}));
      end
      S_OUT: begin
        if (out_load) begin
          mix_out <= sat;
        end
      end
      default: ;
    endcase
  end

endmodule
